FILE: src/linked_peak_limiter_defines.svh
// ----------------------------------------------------------------------------
// linked peak limiter assertion macros
// shared property wrappers clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LINKED_PEAK_LIMITER_DEFINES_SVH
`define LINKED_PEAK_LIMITER_DEFINES_SVH

// same-cycle implication
`define LLIM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/llim_pkg.sv
// ----------------------------------------------------------------------------
// llim_pkg
// types and constants shared by the linked peak limiter modules
// ----------------------------------------------------------------------------
`default_nettype none

package llim_pkg;

	localparam int LANES    = 8;
	localparam int SAMPLE_W = 16;
	localparam int GAIN_W   = 17;
	localparam int COEFF_W  = 16;
	localparam int QUOT_W   = 16;
	localparam int CNT_W    = 4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SAMPLE_W-1:0]        mag_t;
	typedef logic [GAIN_W-1:0]          gain_t;
	typedef logic [COEFF_W-1:0]         coeff_t;
	typedef logic [QUOT_W-1:0]          quot_t;
	typedef logic [CNT_W-1:0]           count_t;
	typedef logic [1:0]                 cfg_index_t;
	typedef logic [15:0]                cfg_data_t;

	localparam gain_t      UNITY_GAIN        = 17'd65536;
	localparam mag_t       CEILING_RESET     = 16'd32768;
	localparam coeff_t     COEFF_RESET       = 16'd65454;
	localparam count_t     CHANNELS_RESET    = 4'd8;

	localparam cfg_index_t REG_CEILING       = 2'd0;
	localparam cfg_index_t REG_RELEASE_COEFF = 2'd1;
	localparam cfg_index_t REG_CHANNELS_USED = 2'd2;

	typedef struct packed {
		logic load;
		logic scale;
		logic fin;
	} lane_ctrl_t;

endpackage

`default_nettype wire

FILE: src/llim_lane.sv
// ----------------------------------------------------------------------------
// llim_lane
// one channel lane: holds the sample, gives its magnitude to the peak merge
// and applies the envelope with round half up and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module llim_lane (
	input  wire                  clk,
	input  llim_pkg::lane_ctrl_t ctrl,
	input  wire                  active,
	input  llim_pkg::sample_t    sample_in,
	input  llim_pkg::gain_t      env,
	output llim_pkg::mag_t       mag,
	output llim_pkg::sample_t    result
);
	import llim_pkg::*;

	sample_t            sample_q;
	logic signed [33:0] prod_q;
	logic signed [17:0] gain_s;
	logic signed [33:0] rnd_sum;
	logic signed [17:0] rnd;
	sample_t            sat;
	sample_t            result_q;

	assign gain_s = {1'b0, env};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_q <= sample_in;
		end
		if (ctrl.scale) begin
			prod_q <= sample_q * gain_s;
		end
		if (ctrl.fin) begin
			result_q <= active ? sat : '0;
		end
	end

	always_comb begin
		mag = '0;
		if (active) begin
			mag = sample_q[SAMPLE_W-1] ? mag_t'(~sample_q + 1'b1) : mag_t'(sample_q);
		end
	end

	// floor(p / 2^16 + 0.5) then clamp to 16 bits
	assign rnd_sum = prod_q + 34'sd32768;
	assign rnd     = rnd_sum[33:16];

	always_comb begin
		if (rnd[17:15] == 3'b000 || rnd[17:15] == 3'b111) begin
			sat = rnd[15:0];
		end else if (rnd[17]) begin
			sat = 16'sh8000;
		end else begin
			sat = 16'sh7fff;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: src/llim_div.sv
// ----------------------------------------------------------------------------
// llim_div
// restoring divider, one quotient bit per cycle: (ceiling << 16) / peak
// valid only while ceiling < peak so the quotient fits in 16 bits
// ----------------------------------------------------------------------------
`default_nettype none

module llim_div (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  llim_pkg::mag_t  dividend,
	input  llim_pkg::mag_t  divisor,
	output logic            done,
	output llim_pkg::quot_t quot
);
	import llim_pkg::*;

	localparam int STEP_W = $clog2(QUOT_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [16:0]       rem_q;
	mag_t              div_q;
	quot_t             quot_q;
	logic [16:0]       rem_sh;
	logic              fits;

	assign rem_sh = {rem_q[15:0], 1'b0};
	assign fits   = rem_sh >= {1'b0, div_q};
	assign done   = busy_q && (step_q == '0);
	assign quot   = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(QUOT_W);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, dividend};
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q && step_q != '0) begin
			rem_q  <= fits ? rem_sh - {1'b0, div_q} : rem_sh;
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

FILE: src/linked_peak_limiter.sv
// sequence: a transferred frame passes the peak, divide, release multiply, envelope
// update, scale and finish steps; the divide step waits for the 16-step restoring
// divider only when the peak is above the ceiling; a new frame is taken only once the
// last has finished, and a stalled result holds the following frame at its last step
// reset: envelope at unity, registers at their defaults, no result pending
// ----------------------------------------------------------------------------
// linked_peak_limiter
// multichannel peak limiter with one linked gain, instant attack and
// one-pole release; lanes scale each channel, a merge stage finds the peak
// ----------------------------------------------------------------------------
`default_nettype none

module linked_peak_limiter #(
	parameter int CHANNELS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  llim_pkg::cfg_index_t cfg_index,
	input  llim_pkg::cfg_data_t  cfg_data,
	input  wire                  frame_valid,
	output logic                 frame_stall,
	input  llim_pkg::sample_t    sample_0,
	input  llim_pkg::sample_t    sample_1,
	input  llim_pkg::sample_t    sample_2,
	input  llim_pkg::sample_t    sample_3,
	input  llim_pkg::sample_t    sample_4,
	input  llim_pkg::sample_t    sample_5,
	input  llim_pkg::sample_t    sample_6,
	input  llim_pkg::sample_t    sample_7,
	output logic                 result_valid,
	input  wire                  result_stall,
	output llim_pkg::sample_t    out_0,
	output llim_pkg::sample_t    out_1,
	output llim_pkg::sample_t    out_2,
	output llim_pkg::sample_t    out_3,
	output llim_pkg::sample_t    out_4,
	output llim_pkg::sample_t    out_5,
	output llim_pkg::sample_t    out_6,
	output llim_pkg::sample_t    out_7,
	output llim_pkg::gain_t      gain
);
	import llim_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PEAK  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_RMUL  = 3'd3;
	localparam logic [2:0] ST_RUPD  = 3'd4;
	localparam logic [2:0] ST_SCALE = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0]       state_q;
	mag_t             ceiling_q;
	coeff_t           coeff_q;
	count_t           chan_used_q;
	gain_t            env_q;
	gain_t            req_q;
	gain_t            gain_q;
	logic             over_q;
	logic             attack_q;
	logic [32:0]      rel_prod_q;
	logic [LANES-1:0] active_q;
	logic             result_valid_q;

	sample_t          frame_samples [LANES];
	mag_t             lane_mag      [LANES];
	sample_t          lane_res      [LANES];
	lane_ctrl_t       lane_ctrl;
	count_t           n_eff;
	mag_t             peak;
	logic             frame_xfer;
	logic             out_busy;
	logic             div_start;
	logic             div_done;
	quot_t            div_quot;
	gain_t            rel_diff;

	assign frame_samples[0] = sample_0;
	assign frame_samples[1] = sample_1;
	assign frame_samples[2] = sample_2;
	assign frame_samples[3] = sample_3;
	assign frame_samples[4] = sample_4;
	assign frame_samples[5] = sample_5;
	assign frame_samples[6] = sample_6;
	assign frame_samples[7] = sample_7;

	assign cfg_ready   = 1'b1;
	assign frame_stall = (state_q != ST_IDLE);
	assign frame_xfer  = frame_valid && !frame_stall;
	assign out_busy    = result_valid_q && result_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q   <= CEILING_RESET;
			coeff_q     <= COEFF_RESET;
			chan_used_q <= CHANNELS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CEILING:       ceiling_q   <= cfg_data;
				REG_RELEASE_COEFF: coeff_q     <= cfg_data;
				REG_CHANNELS_USED: chan_used_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (chan_used_q == '0) begin
			n_eff = count_t'(1);
		end else if (chan_used_q > count_t'(CHANNELS)) begin
			n_eff = count_t'(CHANNELS);
		end else begin
			n_eff = chan_used_q;
		end
	end

	// lanes
	assign lane_ctrl.load  = frame_xfer;
	assign lane_ctrl.scale = (state_q == ST_SCALE);
	assign lane_ctrl.fin   = (state_q == ST_FIN) && !out_busy;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		if (g < CHANNELS) begin : g_on
			llim_lane u_lane (
				.clk       (clk),
				.ctrl      (lane_ctrl),
				.active    (active_q[g]),
				.sample_in (frame_samples[g]),
				.env       (env_q),
				.mag       (lane_mag[g]),
				.result    (lane_res[g])
			);
		end else begin : g_off
			assign lane_mag[g] = '0;
			assign lane_res[g] = '0;
		end
	end

	// peak merge
	always_comb begin
		peak = '0;
		for (int k = 0; k < LANES; k++) begin
			if (lane_mag[k] > peak) begin
				peak = lane_mag[k];
			end
		end
	end

	assign div_start = (state_q == ST_PEAK) && (peak > ceiling_q);

	llim_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ceiling_q),
		.divisor  (peak),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign rel_diff = req_q - env_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			env_q          <= UNITY_GAIN;
			active_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && !lane_ctrl.fin) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (frame_xfer) begin
						for (int k = 0; k < LANES; k++) begin
							active_q[k] <= (count_t'(k) < n_eff);
						end
						state_q <= ST_PEAK;
					end
				end
				ST_PEAK: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!over_q || div_done) begin
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					state_q <= ST_RUPD;
				end
				ST_RUPD: begin
					env_q   <= attack_q ? req_q : req_q - gain_t'(rel_prod_q[32:16]);
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_busy) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_PEAK) begin
			over_q <= peak > ceiling_q;
		end
		if (state_q == ST_DIV) begin
			req_q <= over_q ? gain_t'(div_quot) : UNITY_GAIN;
		end
		if (state_q == ST_RMUL) begin
			attack_q   <= req_q < env_q;
			rel_prod_q <= rel_diff * coeff_q;
		end
		if (lane_ctrl.fin) begin
			gain_q <= env_q;
		end
	end

	assign result_valid = result_valid_q;
	assign gain         = gain_q;
	assign out_0        = lane_res[0];
	assign out_1        = lane_res[1];
	assign out_2        = lane_res[2];
	assign out_3        = lane_res[3];
	assign out_4        = lane_res[4];
	assign out_5        = lane_res[5];
	assign out_6        = lane_res[6];
	assign out_7        = lane_res[7];

`include "linked_peak_limiter_defines.svh"

	`LLIM_ASSERT_NEXT(a_frame_starts, frame_valid && !frame_stall, state_q == ST_PEAK,
		"frame transfer did not start the sequence")
	`LLIM_ASSERT_IMPL(a_env_range, 1'b1, env_q <= UNITY_GAIN, "envelope above unity")
	`LLIM_ASSERT_IMPL(a_gain_range, result_valid, gain <= UNITY_GAIN,
		"result gain above unity")
	`LLIM_ASSERT_NEXT(a_fin_delivers, state_q == ST_FIN && !(result_valid && result_stall),
		result_valid && state_q == ST_IDLE, "finished frame not presented")

endmodule

`default_nettype wire

FILE: test/llim_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llim_checker
// follows register writes and frame transfers, predicts each limited frame
// and its gain, and compares result transfers with them in order
// ----------------------------------------------------------------------------

module llim_checker #(
	parameter int CHANNELS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	input  wire                  cfg_ready,
	input  llim_pkg::cfg_index_t cfg_index,
	input  llim_pkg::cfg_data_t  cfg_data,
	input  wire                  frame_valid,
	input  wire                  frame_stall,
	input  llim_pkg::sample_t    sample_0,
	input  llim_pkg::sample_t    sample_1,
	input  llim_pkg::sample_t    sample_2,
	input  llim_pkg::sample_t    sample_3,
	input  llim_pkg::sample_t    sample_4,
	input  llim_pkg::sample_t    sample_5,
	input  llim_pkg::sample_t    sample_6,
	input  llim_pkg::sample_t    sample_7,
	input  wire                  result_valid,
	input  wire                  result_stall,
	input  llim_pkg::sample_t    out_0,
	input  llim_pkg::sample_t    out_1,
	input  llim_pkg::sample_t    out_2,
	input  llim_pkg::sample_t    out_3,
	input  llim_pkg::sample_t    out_4,
	input  llim_pkg::sample_t    out_5,
	input  llim_pkg::sample_t    out_6,
	input  llim_pkg::sample_t    out_7,
	input  llim_pkg::gain_t      gain,
	output int                   pending,
	output int                   errors
);
	import llim_pkg::*;

	typedef logic [LANES-1:0][SAMPLE_W-1:0] lanes_t;

	typedef struct packed {
		lanes_t lane;
		gain_t  applied;
	} limited_frame_t;

	limited_frame_t frames_due[$];
	limited_frame_t seen;
	limited_frame_t want;
	mag_t           ceiling_cur;
	coeff_t         coeff_cur;
	count_t         used_cur;
	gain_t          envelope;
	int             mismatches = 0;
	int             due_count  = 0;
	int             k;

	assign pending = due_count;
	assign errors  = mismatches;

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("llim_checker: %s at %0t", msg, $time);
		mismatches++;
	endtask

	// peak over active lanes, instant attack, truncated one-pole release,
	// then round half up and saturate each active lane
	function automatic limited_frame_t predict_limited_frame(input lanes_t s);
		limited_frame_t r;
		int             active;
		int             i;
		longint         mag;
		longint         peak;
		longint         need;
		longint         env;
		longint         prod;
		longint         q;
		active = (used_cur == 0) ? 1 : int'(used_cur);
		if (active > CHANNELS)
			active = CHANNELS;
		peak = 0;
		for (i = 0; i < active; i++) begin
			mag = longint'($signed(s[i]));
			if (mag < 0)
				mag = -mag;
			if (mag > peak)
				peak = mag;
		end
		if (peak > longint'(ceiling_cur))
			need = (longint'(ceiling_cur) << 16) / peak;
		else
			need = longint'(UNITY_GAIN);
		env = longint'(envelope);
		if (need < env)
			env = need;
		else
			env = need - (((need - env) * longint'(coeff_cur)) >>> 16);
		envelope = env[GAIN_W-1:0];
		env = longint'(envelope);
		for (i = 0; i < LANES; i++) begin
			if (i < active) begin
				prod = longint'($signed(s[i])) * env + 32768;
				q = prod >>> 16;
				if (q > 32767)
					q = 32767;
				if (q < -32768)
					q = -32768;
				r.lane[i] = q[SAMPLE_W-1:0];
			end else begin
				r.lane[i] = '0;
			end
		end
		r.applied = envelope;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_cur = CEILING_RESET;
			coeff_cur   = COEFF_RESET;
			used_cur    = CHANNELS_RESET;
			envelope    = UNITY_GAIN;
			frames_due.delete();
			due_count   = 0;
			mismatches  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_CEILING: begin
					ceiling_cur = cfg_data;
				end
				REG_RELEASE_COEFF: begin
					coeff_cur = cfg_data;
				end
				REG_CHANNELS_USED: begin
					used_cur = cfg_data[CNT_W-1:0];
				end
				default: begin
				end
				endcase
			end
			if (frame_valid && !frame_stall)
				frames_due.push_back(predict_limited_frame({sample_7, sample_6, sample_5,
					sample_4, sample_3, sample_2, sample_1, sample_0}));
			if (result_valid && !result_stall) begin
				seen.lane    = {out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0};
				seen.applied = gain;
				if (frames_due.size() == 0) begin
					report_mismatch($sformatf("result transfer with no frame due, gain %0d",
						gain));
				end else begin
					want = frames_due.pop_front();
					for (k = 0; k < LANES; k++) begin
						if (seen.lane[k] !== want.lane[k])
							report_mismatch($sformatf("out_%0d got %0d expected %0d", k,
								$signed(seen.lane[k]), $signed(want.lane[k])));
					end
					if (seen.applied !== want.applied)
						report_mismatch($sformatf("gain got %0d expected %0d",
							seen.applied, want.applied));
				end
			end
			due_count = frames_due.size();
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives register writes and audio frames into the linked peak limiter under
// random sender gaps and receiver stalls; a checker beside it predicts results
// ----------------------------------------------------------------------------

module tb;
	import llim_pkg::*;

	localparam int         CHANNELS     = 8;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 30;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         PHASES       = 8;
	localparam int         PHASE_FRAMES = 244;
	localparam cfg_index_t REG_SPARE    = 2'd3;

	typedef logic [LANES-1:0][SAMPLE_W-1:0] lanes_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	cfg_index_t cfg_index    = REG_CEILING;
	cfg_data_t  cfg_data     = '0;
	logic       frame_valid  = 1'b0;
	logic       frame_stall;
	sample_t    sample_0     = '0;
	sample_t    sample_1     = '0;
	sample_t    sample_2     = '0;
	sample_t    sample_3     = '0;
	sample_t    sample_4     = '0;
	sample_t    sample_5     = '0;
	sample_t    sample_6     = '0;
	sample_t    sample_7     = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	sample_t    out_0;
	sample_t    out_1;
	sample_t    out_2;
	sample_t    out_3;
	sample_t    out_4;
	sample_t    out_5;
	sample_t    out_6;
	sample_t    out_7;
	gain_t      gain;
	int         pending;
	int         errors;
	int         cycles       = 0;
	logic       hold_req     = 1'b0;
	logic       quiet        = 1'b0;

	linked_peak_limiter #(.CHANNELS(CHANNELS)) dut (.*);

	llim_checker #(.CHANNELS(CHANNELS)) frame_check (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold on request, none when quiet
	initial begin : result_side
		int span;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				result_stall <= 1'b1;
				span = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (quiet || $urandom_range(0, 3) != 0) begin
				result_stall <= 1'b0;
				span = $urandom_range(1, 20);
			end else begin
				result_stall <= 1'b1;
				span = $urandom_range(1, 10);
			end
			repeat (span) @(posedge clk);
		end
	end

	task automatic drain();
		frame_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input mag_t ceil_v, input coeff_t coeff_v,
		input cfg_data_t chans_v);
		drain();
		write_reg(REG_SPARE, cfg_data_t'($urandom));
		write_reg(REG_CEILING, ceil_v);
		write_reg(REG_RELEASE_COEFF, coeff_v);
		write_reg(REG_CHANNELS_USED, chans_v);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input lanes_t s);
		frame_valid <= 1'b1;
		{sample_7, sample_6, sample_5, sample_4, sample_3, sample_2, sample_1, sample_0} <= s;
		do @(posedge clk); while (frame_stall);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// loud, near full scale, quiet, silent or single loud lane frames
	function automatic lanes_t random_frame();
		lanes_t s;
		int     v;
		int     k;
		int     kind;
		int     loud_lane;
		kind      = $urandom_range(0, 9);
		loud_lane = $urandom_range(0, LANES - 1);
		for (k = 0; k < LANES; k++) begin
			case (kind)
			0, 1, 2: begin
				v = $urandom;
			end
			3, 4: begin
				v = $urandom_range(0, 255);
				v = $urandom_range(0, 1) ? 32767 - v : v - 32768;
			end
			5, 6, 7: begin
				v = $urandom_range(0, 4095);
				v = v - 2048;
			end
			8: begin
				v = 0;
			end
			default: begin
				v = $urandom_range(0, 511);
				v = (k == loud_lane) ? int'($urandom) : v - 256;
			end
			endcase
			s[k] = v[SAMPLE_W-1:0];
		end
		return s;
	endfunction

	initial begin : stimulus
		int phase;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame('0);
		send_frame({LANES{16'h7FFF}});
		send_frame({LANES{16'h8000}});
		send_frame({4{16'h8000, 16'h7FFF}});

		// three active lanes via masked write, instant release
		set_config(16'd16384, 16'd0, 16'hFFF3);
		send_frame({LANES{16'h8000}});
		send_frame({{2{16'h0000}}, 16'h7FFF, {5{16'h0000}}});
		send_frame({{5{16'h0000}}, 16'hC000, 16'h0001, 16'hFFFF});
		send_frame({{5{16'h0000}}, 16'h5000, 16'h0000, 16'h0000});
		send_frame('0);

		// zero ceiling, zero count acts as one lane, slowest release
		set_config(16'd0, 16'hFFFF, 16'h0000);
		send_frame('0);
		send_frame({{7{16'h0000}}, 16'h0001});
		send_frame({{6{16'h0000}}, 16'h7FFF, 16'h0000});
		send_frame('0);
		send_frame('0);

		// ceiling above full scale, count above lanes saturates
		set_config(16'hFFFF, 16'd32768, 16'h000F);
		send_frame({LANES{16'h8000}});
		send_frame(random_frame());
		send_frame(random_frame());

		set_config(16'd1, 16'hFFFF, 16'h0009);
		send_frame({LANES{16'h8000}});
		send_frame({LANES{16'h0001}});
		send_frame('0);

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: set_config(CEILING_RESET, COEFF_RESET, 16'h0008);
			1: set_config(16'd0, 16'd0, 16'h0001);
			2: set_config(16'hFFFF, 16'hFFFF, 16'h0000);
			3: set_config(16'd8192, 16'd60000, 16'h000F);
			4: set_config(16'd32767, 16'd32768, 16'h0005);
			5: set_config(16'd1, 16'd65000, 16'h0002);
			default: set_config(mag_t'($urandom_range(1, 32768)), coeff_t'($urandom),
				cfg_data_t'($urandom));
			endcase
			if (phase == PHASES - 1)
				quiet = 1'b1;
			for (n = 0; n < PHASE_FRAMES; n++) begin
				if (phase == 2 && n == 40)
					hold_req = 1'b1;
				if (phase == 4 && n == 120)
					drain();
				send_frame(random_frame());
			end
		end

		drain();
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
